[design/runlist_vcn_to_lcn_mapper_defines.svh]
// Assertion macros used by the run list mapper core module.
`ifndef RUNLIST_VCN_TO_LCN_MAPPER_DEFINES_SVH
`define RUNLIST_VCN_TO_LCN_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RVLM_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RVLM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rvlm_pkg.sv]
`default_nettype none
package rvlm_pkg;

    localparam logic [32:0] VCN_LIMIT = 33'h1_0000_0000;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_LENGTH = 4'b0100,
        PH_OFFSET = 4'b1000
    } rvlm_phase_t;

    typedef enum logic [1:0] {
        ST_MAPPED = 2'd0,
        ST_SPARSE = 2'd1,
        ST_END    = 2'd2,
        ST_OVER   = 2'd3
    } rvlm_status_t;

    typedef struct packed {
        logic [7:0]  run_byte;
        logic        list_start;
        logic [31:0] target_vcn;
    } rvlm_item_t;

    typedef struct packed {
        logic [63:0]  lcn;
        rvlm_status_t status;
    } rvlm_result_t;

endpackage
`default_nettype wire

[design/rvlm_in_reg.sv]
`default_nettype none
module rvlm_in_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [39:0]       s_tdata,   // run_byte [7:0], target_vcn [39:8]
    input  wire logic              s_tuser,   // list_start
    input  wire logic              fire,
    output logic                   in_valid,
    output rvlm_pkg::rvlm_item_t   item
);
    import rvlm_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    rvlm_item_t item_reg;

    assign s_tready = !in_valid_reg || fire;
    assign in_valid = in_valid_reg;
    assign item     = item_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.run_byte   <= s_tdata[7:0];
            item_reg.list_start <= s_tuser;
            item_reg.target_vcn <= s_tdata[39:8];
        end
    end

endmodule
`default_nettype wire

[design/rvlm_core.sv]
`default_nettype none
`include "runlist_vcn_to_lcn_mapper_defines.svh"
module rvlm_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 fire,
    input  wire rvlm_pkg::rvlm_item_t item,
    output logic                      res_valid,
    output rvlm_pkg::rvlm_result_t    res
);
    import rvlm_pkg::*;

    rvlm_phase_t phase_reg, phase_next;
    logic [2:0]  length_bytes_reg, length_bytes_next;
    logic [2:0]  offset_bytes_reg, offset_bytes_next;
    logic [2:0]  byte_count_reg, byte_count_next;
    logic [55:0] length_acc_reg, length_acc_next;
    logic [55:0] delta_acc_reg, delta_acc_next;
    logic [32:0] vcn_base_reg, vcn_base_next;
    logic [63:0] lcn_base_reg, lcn_base_next;
    logic [31:0] target_reg, target_next;

    rvlm_phase_t phase_eff;
    logic [31:0] target_eff;
    logic [32:0] vcn_base_eff;
    logic [63:0] lcn_base_eff;
    logic [2:0]  bc_inc;
    logic [55:0] len_new;
    logic [55:0] delta_new;
    logic [63:0] delta_wide;
    logic [63:0] delta_ext;
    logic [55:0] fin_len;
    logic [63:0] fin_delta;
    logic [56:0] vcn_end;
    logic [63:0] lcn_end;
    logic        hit;
    logic        run_done;

    always_comb begin
        phase_eff    = item.list_start ? PH_HEADER : phase_reg;
        target_eff   = item.list_start ? item.target_vcn : target_reg;
        vcn_base_eff = item.list_start ? 33'd0 : vcn_base_reg;
        lcn_base_eff = item.list_start ? 64'd0 : lcn_base_reg;
        bc_inc       = byte_count_reg + 3'd1;

        len_new   = length_acc_reg;
        delta_new = delta_acc_reg;
        for (int i = 0; i < 7; i++) begin
            if (byte_count_reg == 3'(i)) begin
                len_new[8*i +: 8]   = len_new[8*i +: 8] | item.run_byte;
                delta_new[8*i +: 8] = delta_new[8*i +: 8] | item.run_byte;
            end
        end

        delta_wide = {8'h00, delta_new};
        for (int i = 0; i < 8; i++) begin
            delta_ext[8*i +: 8] = (3'(i) < offset_bytes_reg) ? delta_wide[8*i +: 8]
                                                              : {8{item.run_byte[7]}};
        end

        fin_len   = (phase_eff == PH_LENGTH) ? len_new : length_acc_reg;
        fin_delta = (phase_eff == PH_LENGTH) ? 64'd0 : delta_ext;
        vcn_end   = {24'd0, vcn_base_eff} + {1'b0, fin_len};
        lcn_end   = lcn_base_eff + fin_delta;
        hit       = (|fin_len) && ({25'd0, target_eff} >= {24'd0, vcn_base_eff})
                    && ({25'd0, target_eff} < vcn_end);
    end

    always_comb begin
        phase_next        = phase_reg;
        length_bytes_next = length_bytes_reg;
        offset_bytes_next = offset_bytes_reg;
        byte_count_next   = byte_count_reg;
        length_acc_next   = length_acc_reg;
        delta_acc_next    = delta_acc_reg;
        vcn_base_next     = vcn_base_eff;
        lcn_base_next     = lcn_base_eff;
        target_next       = target_eff;
        res_valid         = 1'b0;
        res.lcn           = 64'd0;
        res.status        = ST_MAPPED;
        run_done          = 1'b0;

        unique case (phase_eff)
            PH_HEADER: begin
                length_bytes_next = item.run_byte[2:0];
                offset_bytes_next = item.run_byte[6:4];
                if (item.run_byte[2:0] == 3'd0) begin
                    res_valid  = 1'b1;
                    res.status = ST_END;
                    phase_next = PH_IDLE;
                end else begin
                    byte_count_next = 3'd0;
                    length_acc_next = 56'd0;
                    delta_acc_next  = 56'd0;
                    phase_next      = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                length_acc_next = len_new;
                byte_count_next = bc_inc;
                if (bc_inc >= length_bytes_reg) begin
                    byte_count_next = 3'd0;
                    if (offset_bytes_reg == 3'd0) begin
                        run_done = 1'b1;
                    end else begin
                        phase_next = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET: begin
                delta_acc_next  = delta_new;
                byte_count_next = bc_inc;
                if (bc_inc >= offset_bytes_reg) begin
                    byte_count_next = 3'd0;
                    run_done        = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (run_done) begin
            if (hit) begin
                res_valid  = 1'b1;
                phase_next = PH_IDLE;
                if (fin_delta == 64'd0) begin
                    res.status = ST_SPARSE;
                end else begin
                    res.status = ST_MAPPED;
                    res.lcn    = lcn_end;
                end
            end else begin
                vcn_base_next = vcn_end[32:0];
                lcn_base_next = lcn_end;
                if (vcn_end > {24'd0, VCN_LIMIT}) begin
                    res_valid  = 1'b1;
                    res.status = ST_OVER;
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_HEADER;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            length_bytes_reg <= 3'd0;
            offset_bytes_reg <= 3'd0;
            byte_count_reg   <= 3'd0;
            length_acc_reg   <= 56'd0;
            delta_acc_reg    <= 56'd0;
            vcn_base_reg     <= 33'd0;
            lcn_base_reg     <= 64'd0;
            target_reg       <= 32'd0;
        end else if (fire) begin
            phase_reg        <= phase_next;
            length_bytes_reg <= length_bytes_next;
            offset_bytes_reg <= offset_bytes_next;
            byte_count_reg   <= byte_count_next;
            length_acc_reg   <= length_acc_next;
            delta_acc_reg    <= delta_acc_next;
            vcn_base_reg     <= vcn_base_next;
            lcn_base_reg     <= lcn_base_next;
            target_reg       <= target_next;
        end
    end

    `RVLM_ASSERT_NEXT(a_idle_after_result, aclk, aresetn, fire && res_valid, phase_reg == PH_IDLE, "phase not idle after a result")
    `RVLM_ASSERT_IMPLIES(a_length_count, aclk, aresetn, phase_reg == PH_LENGTH, byte_count_reg < length_bytes_reg, "length byte count out of range")
    `RVLM_ASSERT_IMPLIES(a_offset_count, aclk, aresetn, phase_reg == PH_OFFSET, (offset_bytes_reg != 3'd0) && (byte_count_reg < offset_bytes_reg), "offset byte count out of range")
    `RVLM_ASSERT_IMPLIES(a_vcn_base_range, aclk, aresetn, phase_reg != PH_IDLE, vcn_base_reg <= VCN_LIMIT, "running count beyond limit while active")
    `RVLM_ASSERT_IMPLIES(a_unused_lcn_zero, aclk, aresetn, res_valid && (res.status != ST_MAPPED), res.lcn == 64'd0, "lcn not zero on a non-mapped result")

endmodule
`default_nettype wire

[design/rvlm_out_reg.sv]
`default_nettype none
module rvlm_out_reg (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire rvlm_pkg::rvlm_result_t res,
    output logic                        out_ready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [63:0]                 m_tdata,   // lcn [63:0]
    output logic [1:0]                  m_tuser    // status [1:0]
);
    import rvlm_pkg::*;

    logic         m_valid_reg;
    logic         m_valid_next;
    rvlm_result_t res_reg;

    assign out_ready = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = res_reg.lcn;
    assign m_tuser   = res_reg.status;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule
`default_nettype wire

[design/runlist_vcn_to_lcn_mapper.sv]
// A byte waits in the input register; its result, if any, is held in the output register.
// Throughput: one run list byte per cycle; a byte stalls only while a result waits on m_tready.
// The per-byte decode is one pass through the core between input and result registers.
// Reset: synchronous aresetn (active low) empties both stages and clears the list state;
// bytes are then ignored until one arrives with list_start set.
`default_nettype none
module runlist_vcn_to_lcn_mapper (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // run_byte [7:0], target_vcn [39:8]
    input  wire logic        s_tuser,   // list_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // lcn [63:0]
    output logic [1:0]       m_tuser    // status [1:0]
);
    import rvlm_pkg::*;

    logic         in_valid;
    logic         out_ready;
    logic         fire;
    logic         res_valid;
    rvlm_item_t   item;
    rvlm_result_t res;

    assign fire = in_valid && out_ready;

    rvlm_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .fire     (fire),
        .in_valid (in_valid),
        .item     (item)
    );

    rvlm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    rvlm_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire && res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
